/* rtl/core/sobel_pkg.sv */
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants of the Sobel edge block: beat layouts,
// configuration register indexes and the root chain state.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH     = 2'd0,
        CFG_FRAME_HEIGHT   = 2'd1,
        CFG_LOW_THRESHOLD  = 2'd2,
        CFG_HIGH_THRESHOLD = 2'd3
    } t_cfg_idx;

    localparam logic [8:0] RST_LINE_WIDTH     = 9'd184;
    localparam logic [8:0] RST_FRAME_HEIGHT   = 9'd120;
    localparam logic [7:0] RST_LOW_THRESHOLD  = 8'd150;
    localparam logic [7:0] RST_HIGH_THRESHOLD = 8'd200;
    localparam logic [7:0] EDGE_SAT           = 8'd255;
    localparam logic [7:0] EDGE_ZERO          = 8'd0;

    // Root chain: a 16-bit radicand needs eight two-bit steps.
    localparam int SQRT_W     = 16;
    localparam int SQRT_STEPS = 8;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] edge_res;
        logic [7:0] out_col;
        logic [7:0] out_row;
        logic       last;
    } t_out_beat;

    typedef struct packed {
        logic              valid;
        logic [SQRT_W-1:0] rem;
        logic [SQRT_W-1:0] root;
    } t_sqrt_state;

endpackage

/* rtl/core/sobel_ram.sv */
// ----------------------------------------------------------------------------
// sobel_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/sobel_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// sobel_sqrt_cell
// One step of the digit-by-digit integer square root. Cells are chained;
// each takes remainder and partial root from its left neighbour every cycle.
// ----------------------------------------------------------------------------
module sobel_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  sobel_pkg::t_sqrt_state i_cur,
    output sobel_pkg::t_sqrt_state o_nxt
);

    import sobel_pkg::*;

    // Trial bit for this step: 4^(7-STEP).
    localparam logic [SQRT_W-1:0] TRIAL = SQRT_W'(1) << (SQRT_W - 2 - 2 * STEP);

    logic [SQRT_W:0]   trial_sum;
    logic              fits;
    t_sqrt_state       n_st;
    t_sqrt_state       r_st;

    always_comb begin
        trial_sum = {1'b0, i_cur.root} + {1'b0, TRIAL};
        fits      = {1'b0, i_cur.rem} >= trial_sum;
        n_st.valid = i_cur.valid;
        if (fits) begin
            n_st.rem  = i_cur.rem - trial_sum[SQRT_W-1:0];
            n_st.root = (i_cur.root >> 1) + TRIAL;
        end else begin
            n_st.rem  = i_cur.rem;
            n_st.root = i_cur.root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.valid <= 1'b0;
        end else begin
            r_st.valid <= n_st.valid;
        end
        r_st.rem  <= n_st.rem;
        r_st.root <= n_st.root;
    end

    assign o_nxt = r_st;

endmodule

/* rtl/core/sobel_edge_threshold.sv */
// ----------------------------------------------------------------------------
// sobel_edge_threshold
// Streaming 3x3 Sobel edge magnitude with low/high thresholding.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order; each interior pixel yields one beat with
// the thresholded magnitude of the window centre and its position, border
// pixels yield none. One pixel is in flight at a time and passes from
// acceptance to the output register through these stages: line store read
// at acceptance, then gradient, square, sum and compare, eight cells of the
// square-root chain, a holding stage and the output register. The input
// stalls until the pixel leaves the pipeline: at the chain end for a pixel
// without a result, on the move into a free output register for one with a
// result; a stalled sink holds the result in the holding stage.
// A finished result may wait in the output register while the next
// pixel is being worked on. The line store is a RAM of MAX_WIDTH entries
// needing no clearing pass. Sizes are clamped to 3..MAX_WIDTH / MAX_HEIGHT.
// ----------------------------------------------------------------------------
module sobel_edge_threshold #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  sobel_pkg::t_in_beat                 i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output sobel_pkg::t_out_beat                o_out_data,
    input  logic                                i_cfg_we,
    input  sobel_pkg::t_cfg_idx                 i_cfg_idx,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    import sobel_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int LWW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int LHW = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int XCW = (CW > 8) ? CW : 8;
    localparam int XRW = (RW > 8) ? RW : 8;

    // configuration
    logic [8:0]  r_line_width;
    logic [8:0]  r_frame_height;
    logic [7:0]  r_low_thr;
    logic [7:0]  r_high_thr;
    logic [15:0] r_lo2;
    logic [15:0] r_hi2;

    // position and window state
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [47:0]   r_win;

    // front of the pipeline
    logic          r_busy;
    logic          r_v1;
    logic          r_v2;
    logic          r_v3;
    logic [7:0]    r_px;
    logic [CW-1:0] r_acol;
    logic [RW-1:0] r_arow;
    logic          r_emit;
    logic          r_last;
    logic signed [10:0] r_ga;
    logic signed [10:0] r_gb;
    logic [19:0]   r_sqa;
    logic [19:0]   r_sqb;
    logic          r_zero;
    logic          r_sat;
    t_sqrt_state   r_chain_in;

    // result side
    logic          r_hold_valid;
    t_out_beat     r_hold;
    logic          r_out_valid;
    t_out_beat     r_out;

    logic [WW-1:0] w_size;
    logic [HW-1:0] h_size;
    logic          in_take;
    logic          out_free;
    logic          hold_move;
    logic          chain_done;

    logic [CW-1:0] c0;
    logic [RW-1:0] r0;
    logic [CW-1:0] cur_col;
    logic [HW-1:0] row_inc;
    logic [RW-1:0] cur_row;
    logic [WW-1:0] nxt_col;
    logic [HW-1:0] nxt_row;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          cur_emit;
    logic          cur_last;

    logic [15:0]   rd_entry;
    logic [7:0]    a00, a01, a02, a10, a12, a20, a21, a22;
    logic [9:0]    ga_pos, ga_neg, gb_pos, gb_neg;
    logic signed [21:0] sq_a;
    logic signed [21:0] sq_b;
    logic [20:0]   s_sum;
    t_sqrt_state   chain [SQRT_STEPS+1];

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= RST_LINE_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_low_thr      <= RST_LOW_THRESHOLD;
            r_high_thr     <= RST_HIGH_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LINE_WIDTH:     r_line_width   <= i_cfg_data;
                CFG_FRAME_HEIGHT:   r_frame_height <= i_cfg_data;
                CFG_LOW_THRESHOLD:  r_low_thr      <= i_cfg_data[7:0];
                CFG_HIGH_THRESHOLD: r_high_thr     <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // squared thresholds so the compares need no root
    always_ff @(posedge i_clk) begin
        r_lo2 <= 16'(r_low_thr) * 16'(r_low_thr);
        r_hi2 <= 16'(r_high_thr) * 16'(r_high_thr);
    end

    always_comb begin
        if (LWW'(r_line_width) < LWW'(3)) begin
            w_size = WW'(3);
        end else if (LWW'(r_line_width) > LWW'(MAX_WIDTH)) begin
            w_size = WW'(MAX_WIDTH);
        end else begin
            w_size = WW'(r_line_width);
        end
        if (LHW'(r_frame_height) < LHW'(3)) begin
            h_size = HW'(3);
        end else if (LHW'(r_frame_height) > LHW'(MAX_HEIGHT)) begin
            h_size = HW'(MAX_HEIGHT);
        end else begin
            h_size = HW'(r_frame_height);
        end
    end

    // ------------------------------------------------------------- position
    assign in_take    = i_in_valid && !r_busy;
    assign o_in_stall = r_busy;

    always_comb begin
        c0 = i_in_data.frame_start ? '0 : r_col;
        r0 = i_in_data.frame_start ? '0 : r_row;
        // counters may sit beyond a size that was just made smaller
        if (WW'(c0) >= w_size) begin
            cur_col = '0;
            row_inc = HW'(r0) + HW'(1);
        end else begin
            cur_col = c0;
            row_inc = HW'(r0);
        end
        cur_row = (row_inc >= h_size) ? '0 : RW'(row_inc);

        cur_emit = (cur_col >= CW'(2)) && (cur_row >= RW'(2));
        cur_last = (WW'(cur_col) == w_size - WW'(1)) && (HW'(cur_row) == h_size - HW'(1));

        nxt_col = WW'(cur_col) + WW'(1);
        nxt_row = HW'(cur_row);
        if (nxt_col >= w_size) begin
            nxt_col = '0;
            nxt_row = HW'(cur_row) + HW'(1);
            if (nxt_row >= h_size) begin
                nxt_row = '0;
            end
        end
        n_col = CW'(nxt_col);
        n_row = RW'(nxt_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_take) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_px   <= i_in_data.pixel;
            r_acol <= cur_col;
            r_arow <= cur_row;
            r_emit <= cur_emit;
            r_last <= cur_last;
        end
    end

    // ----------------------------------------------------------- line store
    // high byte: two rows up, low byte: one row up
    sobel_ram #(
        .WIDTH (16),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_v1),
        .i_waddr (r_acol),
        .i_wdata ({rd_entry[7:0], r_px}),
        .i_raddr (cur_col),
        .o_rdata (rd_entry)
    );

    // -------------------------------------------------------------- window
    // aCR: column C (0 oldest), row R (0 top)
    always_comb begin
        a00 = r_win[23:16];
        a01 = r_win[15:8];
        a02 = r_win[7:0];
        a10 = r_win[47:40];
        a12 = r_win[31:24];
        a20 = rd_entry[15:8];
        a21 = rd_entry[7:0];
        a22 = r_px;
        ga_pos = 10'(a02) + {1'b0, a12, 1'b0} + 10'(a22);
        ga_neg = 10'(a00) + {1'b0, a10, 1'b0} + 10'(a20);
        gb_pos = 10'(a20) + {1'b0, a21, 1'b0} + 10'(a22);
        gb_neg = 10'(a00) + {1'b0, a01, 1'b0} + 10'(a02);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_v1) begin
            r_win <= {a20, a21, a22, r_win[47:24]};
        end
    end

    always_ff @(posedge i_clk) begin
        r_ga <= signed'({1'b0, ga_pos}) - signed'({1'b0, ga_neg});
        r_gb <= signed'({1'b0, gb_pos}) - signed'({1'b0, gb_neg});
    end

    assign sq_a = r_ga * r_ga;
    assign sq_b = r_gb * r_gb;

    always_ff @(posedge i_clk) begin
        r_sqa <= sq_a[19:0];
        r_sqb <= sq_b[19:0];
    end

    assign s_sum = {1'b0, r_sqa} + {1'b0, r_sqb};

    always_ff @(posedge i_clk) begin
        if (r_v3) begin
            r_zero <= s_sum < 21'(r_lo2);
            r_sat  <= s_sum > 21'(r_hi2);
        end
        if (!i_rst_n) begin
            r_chain_in.valid <= 1'b0;
        end else begin
            r_chain_in.valid <= r_v3;
        end
        r_chain_in.rem  <= s_sum[SQRT_W-1:0];
        r_chain_in.root <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= in_take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // ---------------------------------------------------------- root chain
    assign chain[0] = r_chain_in;

    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_cell
        sobel_sqrt_cell #(
            .STEP (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cur   (chain[g]),
            .o_nxt   (chain[g+1])
        );
    end

    assign chain_done = chain[SQRT_STEPS].valid;

    // -------------------------------------------------------- result side
    assign out_free  = !r_out_valid || !i_out_stall;
    assign hold_move = r_hold_valid && out_free;

    always_ff @(posedge i_clk) begin
        if (chain_done) begin
            if (r_zero) begin
                r_hold.edge_res <= EDGE_ZERO;
            end else if (r_sat) begin
                r_hold.edge_res <= EDGE_SAT;
            end else begin
                r_hold.edge_res <= chain[SQRT_STEPS].root[7:0];
            end
            r_hold.out_col <= 8'(XCW'(r_acol) - XCW'(1));
            r_hold.out_row <= 8'(XRW'(r_arow) - XRW'(1));
            r_hold.last    <= r_last;
        end
        if (hold_move) begin
            r_out <= r_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_take) begin
                r_busy <= 1'b1;
            end else if ((chain_done && !r_emit) || hold_move) begin
                r_busy <= 1'b0;
            end

            if (chain_done && r_emit) begin
                r_hold_valid <= 1'b1;
            end else if (hold_move) begin
                r_hold_valid <= 1'b0;
            end

            if (hold_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* dv/sobel_edge_threshold_test.sv */
// ----------------------------------------------------------------------------
// sobel_edge_threshold_test
// Self-checking bench for the Sobel edge block. Pixel beats stream in under
// bursty valid, results leave under a wandering stall. Each accepted pixel
// is run through an in-bench copy of the filter (line store, window,
// gradients, exact root, thresholds) and every result beat is checked
// field by field against the queue of predicted edges. Reset-size noise
// opens the run, then a short hand-made table, then random frames under
// a range of sizes and thresholds, including clamped sizes and crossed ones.
// ----------------------------------------------------------------------------
module sobel_edge_threshold_test;
    import sobel_pkg::*;

    localparam int MAX_WIDTH     = 256;
    localparam int MAX_HEIGHT    = 256;
    localparam int SETTLE_CYCLES = 40;    // covers a pixel still in flight
    localparam int IDLE_LIMIT    = 4000;
    localparam int PROBE_ROWS    = 27;

    typedef enum logic [1:0] {
        TEX_NOISE,
        TEX_SOFT,
        TEX_STARK
    } t_texture;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_CHOPPY,
        SINK_SLUGGISH
    } t_sink_mode;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
        logic       typed;
        t_out_beat  want;
    } t_probe;

    typedef struct packed {
        logic [8:0]  width;
        logic [8:0]  height;
        logic [7:0]  low;
        logic [7:0]  high;
        int unsigned pixels;
        logic        fresh_frame;
        t_texture    texture;
    } t_scene;

    // Three 3x3 frames: flat, a hard vertical edge, then a soft horizontal
    // edge that starts by wrapping past the end of the previous frame.
    localparam t_probe PROBES [PROBE_ROWS] = '{
        '{8'd0,   1'b1, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b1, '{EDGE_ZERO, 8'd1, 8'd1, 1'b1}},
        '{8'd0,   1'b1, 1'b0, '0},
        '{8'd128, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd128, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd128, 1'b0, 1'b0, '0},
        '{8'd255, 1'b0, 1'b1, '{EDGE_SAT, 8'd1, 8'd1, 1'b1}},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd17,  1'b0, 1'b0, '0},
        '{8'd0,   1'b0, 1'b0, '0},
        '{8'd40,  1'b0, 1'b0, '0},
        '{8'd40,  1'b0, 1'b0, '0},
        '{8'd40,  1'b0, 1'b0, '0}
    };

    // Clamped sizes at both ends, crossed and equal thresholds, and a
    // shrink without frame start so the counters wrap on the new sizes.
    localparam int SCENE_COUNT = 6;
    localparam t_scene SCENES [SCENE_COUNT] = '{
        '{9'd0,   9'd2,   8'd0,   8'd255, 30,  1'b1, TEX_NOISE},
        '{9'd5,   9'd4,   8'd255, 8'd0,   40,  1'b1, TEX_SOFT},
        '{9'd511, 9'd3,   8'd60,  8'd120, 530, 1'b1, TEX_SOFT},
        '{9'd3,   9'd511, 8'd100, 8'd180, 770, 1'b1, TEX_NOISE},
        '{9'd12,  9'd9,   8'd30,  8'd90,  80,  1'b1, TEX_SOFT},
        '{9'd5,   9'd4,   8'd200, 8'd200, 60,  1'b0, TEX_STARK}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_beat              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_data;
    logic                  cfg_we = 1'b0;
    t_cfg_idx              cfg_idx = CFG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // filter copy
    logic [8:0]  width_reg = RST_LINE_WIDTH;
    logic [8:0]  height_reg = RST_FRAME_HEIGHT;
    logic [7:0]  low_reg = RST_LOW_THRESHOLD;
    logic [7:0]  high_reg = RST_HIGH_THRESHOLD;
    logic [15:0] line_mem [MAX_WIDTH] = '{default: '0};
    logic [7:0]  left_col [3] = '{default: '0};
    logic [7:0]  mid_col [3] = '{default: '0};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    t_out_beat   pending_edges [$];
    t_out_beat   head_edge;
    int          mismatches = 0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    t_sink_mode  sink_mode = SINK_OPEN;
    int          sink_left = 0;

    sobel_edge_threshold #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [8:0] raw, input int unsigned top);
        if (raw < 9'd3) return 3;
        if ({23'd0, raw} > top) return top;
        return {23'd0, raw};
    endfunction

    function automatic logic [7:0] floor_root(input int unsigned sq);
        logic [7:0]  root;
        int unsigned trial;
        root = '0;
        for (int b = 7; b >= 0; b--) begin
            trial = root | (1 << b);
            if (trial * trial <= sq) root = 8'(trial);
        end
        return root;
    endfunction

    // Advances the filter copy by one pixel; returns 1 with the edge beat
    // when the pixel closes an interior window.
    function automatic bit edge_of_pixel(input t_in_beat beat, output t_out_beat res);
        int unsigned w, h, col, row, sq, lo2, hi2;
        int          l0, l1, l2, m0, m2, r0, r1, r2, gv, gh;
        logic [7:0]  slot;
        logic [15:0] entry;
        logic [7:0]  right_col [3];
        bit          emits;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        if (beat.frame_start) begin
            col_pos = 0;
            row_pos = 0;
        end
        // a size shrunk below the counter wraps it straight away
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (row_pos >= h) row_pos = 0;
        col = col_pos;
        row = row_pos;
        slot = 8'(col);
        entry = line_mem[slot];
        right_col[0] = entry[15:8];
        right_col[1] = entry[7:0];
        right_col[2] = beat.pixel;
        emits = (col >= 2) && (row >= 2);
        res = '0;
        if (emits) begin
            l0 = int'(left_col[0]);
            l1 = int'(left_col[1]);
            l2 = int'(left_col[2]);
            m0 = int'(mid_col[0]);
            m2 = int'(mid_col[2]);
            r0 = int'(right_col[0]);
            r1 = int'(right_col[1]);
            r2 = int'(right_col[2]);
            gv = -l0 + l2 - 2 * m0 + 2 * m2 - r0 + r2;
            gh = -l0 - 2 * l1 - l2 + r0 + 2 * r1 + r2;
            sq = unsigned'(gv * gv + gh * gh);
            lo2 = {24'd0, low_reg};
            hi2 = {24'd0, high_reg};
            lo2 = lo2 * lo2;
            hi2 = hi2 * hi2;
            // low test wins when the thresholds cross
            if (sq < lo2) res.edge_res = EDGE_ZERO;
            else if (sq > hi2) res.edge_res = EDGE_SAT;
            else res.edge_res = floor_root(sq);
            res.out_col = 8'(col - 1);
            res.out_row = 8'(row - 1);
            res.last = (col == w - 1) && (row == h - 1);
        end
        line_mem[slot] = {entry[7:0], beat.pixel};
        left_col = mid_col;
        mid_col = right_col;
        col_pos = col + 1;
        row_pos = row;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos = row + 1;
            if (row_pos >= h) row_pos = 0;
        end
        return emits;
    endfunction

    task automatic write_settings(input logic [8:0] w, input logic [8:0] h,
                                  input logic [7:0] lo, input logic [7:0] hi);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_LINE_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_idx <= CFG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_idx <= CFG_LOW_THRESHOLD;
        cfg_data <= {1'b0, lo};
        @(posedge clk);
        cfg_idx <= CFG_HIGH_THRESHOLD;
        cfg_data <= {1'b0, hi};
        @(posedge clk);
        cfg_we <= 1'b0;
        width_reg = w;
        height_reg = h;
        low_reg = lo;
        high_reg = hi;
    endtask

    task automatic send_pixel(input t_in_beat beat, input bit typed, input t_out_beat typed_res);
        t_out_beat res;
        bit        emits;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data <= beat;
        do @(posedge clk); while (in_stall);
        burst_left--;
        emits = edge_of_pixel(beat, res);
        if (typed) pending_edges.push_back(typed_res);
        else if (emits) pending_edges.push_back(res);
    endtask

    task automatic feed_frames(input int unsigned count, input bit fresh_frame,
                               input t_texture texture);
        t_in_beat beat;
        int       base;
        base = $urandom_range(0, 192);
        for (int n = 0; n < count; n++) begin
            case (texture)
                TEX_SOFT:  beat.pixel = 8'(base + $urandom_range(0, 63));
                TEX_STARK: beat.pixel = ($urandom_range(0, 1) == 1) ? 8'd255 : 8'd0;
                default:   beat.pixel = 8'($urandom_range(0, 255));
            endcase
            // stray frame starts now and then, mid-frame
            beat.frame_start = (n == 0 && fresh_frame) || ($urandom_range(0, 199) == 0);
            send_pixel(beat, 1'b0, '0);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // result checking and the sink's stall pattern
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_edges.size() == 0) begin
                $display("%0t: unexpected beat expected none actual %h", $time, out_data);
                mismatches++;
            end else begin
                head_edge = pending_edges.pop_front();
                check_field("edge_res", head_edge.edge_res, out_data.edge_res);
                check_field("out_col", head_edge.out_col, out_data.out_col);
                check_field("out_row", head_edge.out_row, out_data.out_row);
                check_field("last", {7'd0, head_edge.last}, {7'd0, out_data.last});
            end
        end
        if (sink_left == 0) begin
            sink_mode = t_sink_mode'($urandom_range(0, 2));
            sink_left = $urandom_range(40, 400);
        end else begin
            sink_left--;
        end
        case (sink_mode)
            SINK_OPEN:   out_stall <= 1'b0;
            SINK_CHOPPY: out_stall <= ($urandom_range(0, 1) == 1);
            default: begin
                if ($urandom_range(0, 11) == 0) out_stall <= !out_stall;
            end
        endcase
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("sobel_edge_threshold regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_in_beat beat;
        t_scene   scene;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset sizes: enough pixels to get past the first two rows
        feed_frames(380, 1'b1, TEX_NOISE);
        settle();

        write_settings(9'd3, 9'd3, 8'd150, 8'd200);
        for (int i = 0; i < PROBE_ROWS; i++) begin
            beat.pixel = PROBES[i].pixel;
            beat.frame_start = PROBES[i].frame_start;
            send_pixel(beat, PROBES[i].typed, PROBES[i].want);
        end
        settle();

        for (int i = 0; i < SCENE_COUNT; i++) begin
            scene = SCENES[i];
            write_settings(scene.width, scene.height, scene.low, scene.high);
            feed_frames(scene.pixels, scene.fresh_frame, scene.texture);
            settle();
        end

        repeat (2) begin
            scene.width = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 2))
                                                      : 9'($urandom_range(3, 20));
            scene.height = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(257, 511))
                                                       : 9'($urandom_range(3, 10));
            scene.low = 8'($urandom_range(0, 255));
            scene.high = 8'($urandom_range(0, 255));
            scene.texture = t_texture'($urandom_range(0, 2));
            write_settings(scene.width, scene.height, scene.low, scene.high);
            feed_frames($urandom_range(20, 60), $urandom_range(0, 3) != 0, scene.texture);
            settle();
        end

        if (mismatches == 0) begin
            $display("sobel_edge_threshold regression: pass");
        end else begin
            $display("sobel_edge_threshold regression: fail");
        end
        $finish;
    end

endmodule
